>>> rtl/src_pkg.sv
// Shared constants and status codes for the cubic secant root finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package src_pkg;
  localparam int FRAC_BITS = 20;
  localparam int VW        = 32;             // value width, Q12.20
  localparam int MW        = 34;             // shared multiplier operand width
  localparam int PW        = 2 * MW;         // multiplier product width
  localparam int SQW       = 43;             // x^2 magnitude after scaling
  localparam int CUW       = 54;             // x^3 magnitude after scaling
  localparam int FW        = 56;             // signed f(x)
  localparam int FMW       = 55;             // |f| width
  localparam int DXW       = 33;             // |x1 - x0| width
  localparam int NUMW      = 88;             // |f1| * |dx| width
  localparam int DVW       = 56;             // |f1 - f0| width
  localparam int QW        = 34;             // capped quotient width
  localparam int QCAP_BIT  = VW + 1;         // quotient cap is 2^(VW+1)
  localparam int XEW       = 36;             // signed width for x1 - step
  localparam int TOLW      = 21;
  localparam int LIMW      = 10;
  localparam int CIW       = 2;              // config index width
  localparam int DIVCW     = 7;              // divider bit counter

  localparam logic [CIW-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CIW-1:0] REG_LIMIT     = 2'd1;

  localparam logic [TOLW-1:0] TOL_RESET = 21'd2;
  localparam logic [LIMW-1:0] LIM_RESET = 10'd1000;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_FLAT      = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
endpackage
`default_nettype wire

>>> rtl/src_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on src_pkg.
`timescale 1ns / 1ps
`default_nettype none
module src_mul import src_pkg::*; (
  input  wire logic          clk,
  input  wire logic [MW-1:0] a,
  input  wire logic [MW-1:0] b,
  output logic      [PW-1:0] p
);
  always_ff @(posedge clk) begin
    p <= PW'(a) * PW'(b);
  end
endmodule
`default_nettype wire

>>> rtl/src_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, capped quotient.
// Depends on src_pkg.
`timescale 1ns / 1ps
`default_nettype none
module src_div import src_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [DVW-1:0]  dv,
  output logic                 done,
  output logic      [QW-1:0]   q
);
  logic [NUMW-1:0]  numsh;
  logic [DVW-1:0]   rem;
  logic [DVW-1:0]   dvr;
  logic [QW-1:0]    qr;
  logic             sat;
  logic             run;
  logic [DIVCW-1:0] idx;
  logic [DVW:0]     rs;
  logic             ge;
  logic [DVW:0]     diff;
  logic             cap;

  assign rs   = {rem, numsh[NUMW-1]};
  assign ge   = rs >= {1'b0, dvr};
  assign diff = rs - {1'b0, dvr};
  assign cap  = sat | (qr[QW-1] & (|qr[QW-2:0]));
  assign q    = cap ? (QW'(1) << QCAP_BIT) : qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && idx == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numsh <= num;
      dvr   <= dv;
      rem   <= '0;
      qr    <= '0;
      sat   <= 1'b0;
      idx   <= DIVCW'(NUMW - 1);
    end else if (run) begin
      rem   <= ge ? diff[DVW-1:0] : rs[DVW-1:0];
      numsh <= {numsh[NUMW-2:0], 1'b0};
      qr    <= {qr[QW-2:0], ge};
      // a set bit at or above the quotient width means overflow
      if (ge && idx >= DIVCW'(QW)) sat <= 1'b1;
      idx   <= idx - 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> rtl/secant_root_finder_cubic.sv
// Secant root finder for f(x) = x^3 - x^2 + 2, Q12.20 values.
// Each f(x) runs S_SQ, S_CU0, S_CU1, S_FIN (f(x0), f(x1) up front); an iteration
// runs S_STEP, S_PM0-S_PM2, S_DIV (bit-serial 88-bit divider), then the next f(x1).
// Throughput: one item at a time; busy drops in the cycle of the result strobe.
// Reset: synchronous, clears control and loads tolerance 2, limit 1000.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module secant_root_finder_cubic import src_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [VW-1:0]   first_guess,
  input  wire logic signed [VW-1:0]   second_guess,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic        [CIW-1:0]  cfg_index,
  input  wire logic        [TOLW-1:0] cfg_data,
  output logic                        done,
  output logic signed      [VW-1:0]   root,
  output logic             [LIMW-1:0] iterations_used,
  output logic             [1:0]      status
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SQ   = 10'b0000000010,
    S_CU0  = 10'b0000000100,
    S_CU1  = 10'b0000001000,
    S_FIN  = 10'b0000010000,
    S_STEP = 10'b0000100000,
    S_PM0  = 10'b0001000000,
    S_PM1  = 10'b0010000000,
    S_PM2  = 10'b0100000000,
    S_DIV  = 10'b1000000000
  } state_t;

  state_t state;
  logic [TOLW-1:0] tol;
  logic [LIMW-1:0] lim;
  logic [LIMW-1:0] cnt;
  logic signed [VW-1:0] x0, x1;
  logic signed [FW-1:0] f0, f1;
  logic [VW-1:0]   m;
  logic            xneg;
  logic            eval0;
  logic [SQW-1:0]  sq;
  logic [NUMW-1:0] acc;
  logic [FMW-1:0]  fm;
  logic [DXW-1:0]  dxm;
  logic [DVW-1:0]  dvm;
  logic            qneg;
  logic            upd;

  logic [MW-1:0] ma, mb;
  logic [PW-1:0] p;
  logic          div_start, div_done;
  logic [QW-1:0] q;

  logic [NUMW-1:0] sum_w;
  logic [CUW-1:0]  cu;
  logic signed [FW-1:0] cus, fval, d;
  logic signed [DXW-1:0] dx;
  logic signed [XEW-1:0] qs, x2w;
  logic signed [VW-1:0]  x2;
  logic signed [DXW:0]   dif;
  logic [DXW:0]          difm;

  src_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(p));

  src_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_w), .dv(dvm),
    .done(div_done), .q(q)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign div_start = (state == S_PM2);

  // operand select for the shared multiplier
  always_comb begin
    ma = {(MW-VW)'(0), m};
    mb = {(MW-VW)'(0), m};
    unique case (state)
      S_CU0: ma = p[FRAC_BITS+MW-1:FRAC_BITS];
      S_CU1: ma = MW'(sq[SQW-1:MW]);
      S_PM0: begin
        ma = fm[MW-1:0];
        mb = MW'(dxm);
      end
      S_PM1: begin
        ma = MW'(fm[FMW-1:MW]);
        mb = MW'(dxm);
      end
      default: ;
    endcase
  end

  always_comb begin
    sum_w = acc + {p[NUMW-MW-1:0], MW'(0)};
    cu    = sum_w[CUW+FRAC_BITS-1:FRAC_BITS];
    cus   = xneg ? -FW'(signed'({1'b0, cu})) : FW'(signed'({1'b0, cu}));
    fval  = cus - FW'(signed'({1'b0, sq})) + (FW'(2) <<< FRAC_BITS);
    d     = f1 - f0;
    dx    = DXW'(x1) - DXW'(x0);
    qs    = qneg ? -XEW'(signed'({1'b0, q})) : XEW'(signed'({1'b0, q}));
    x2w   = XEW'(x1) - qs;
    if (x2w > XEW'(signed'({1'b0, {(VW-1){1'b1}}})))
      x2 = {1'b0, {(VW-1){1'b1}}};
    else if (x2w < -XEW'(signed'({1'b0, {(VW-1){1'b1}}})) - XEW'(1))
      x2 = {1'b1, (VW-1)'(0)};
    else
      x2 = x2w[VW-1:0];
    dif   = (DXW+1)'(x2) - (DXW+1)'(x1);
    difm  = dif[DXW] ? (DXW+1)'(-dif) : (DXW+1)'(dif);
    upd   = difm >= (DXW+1)'(tol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      tol   <= TOL_RESET;
      lim   <= LIM_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TOLERANCE: tol <= cfg_data;
          REG_LIMIT:     lim <= cfg_data[LIMW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x0    <= first_guess;
            x1    <= second_guess;
            cnt   <= '0;
            eval0 <= 1'b1;
            m     <= first_guess[VW-1] ? VW'(-first_guess) : VW'(first_guess);
            xneg  <= first_guess[VW-1];
            if (lim == '0) begin
              done            <= 1'b1;
              root            <= second_guess;
              iterations_used <= '0;
              status          <= ST_LIMIT;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ:  state <= S_CU0;
        S_CU0: begin
          sq    <= p[SQW+FRAC_BITS-1:FRAC_BITS];
          state <= S_CU1;
        end
        S_CU1: begin
          acc   <= NUMW'(p);
          state <= S_FIN;
        end
        S_FIN: begin
          if (eval0) begin
            f0    <= fval;
            eval0 <= 1'b0;
            m     <= x1[VW-1] ? VW'(-x1) : VW'(x1);
            xneg  <= x1[VW-1];
            state <= S_SQ;
          end else begin
            f1    <= fval;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (cnt == lim) begin
            done            <= 1'b1;
            root            <= x1;
            iterations_used <= lim;
            status          <= ST_LIMIT;
            state           <= S_IDLE;
          end else if (d == '0) begin
            done            <= 1'b1;
            root            <= x1;
            iterations_used <= cnt;
            status          <= ST_FLAT;
            state           <= S_IDLE;
          end else begin
            fm    <= f1[FW-1] ? FMW'(-f1) : FMW'(f1);
            dxm   <= dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
            dvm   <= d[FW-1] ? DVW'(-d) : DVW'(d);
            qneg  <= (f1[FW-1] ^ dx[DXW-1]) ^ d[FW-1];
            state <= S_PM0;
          end
        end
        S_PM0: state <= S_PM1;
        S_PM1: begin
          acc   <= NUMW'(p);
          state <= S_PM2;
        end
        S_PM2: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (!upd) begin
              done            <= 1'b1;
              root            <= x2;
              iterations_used <= cnt + 1'b1;
              status          <= ST_CONVERGED;
              state           <= S_IDLE;
            end else begin
              // advance the pair; f(x1) becomes f(x0)
              x0    <= x1;
              x1    <= x2;
              f0    <= f1;
              cnt   <= cnt + 1'b1;
              m     <= x2[VW-1] ? VW'(-x2) : VW'(x2);
              xneg  <= x2[VW-1];
              state <= S_SQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/src_checker.sv
// Port-level checker for the secant root finder, bound to the top level.
// Depends on src_pkg.
`timescale 1ns / 1ps
`default_nettype none
module src_checker import src_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status
);
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_CONVERGED || status == ST_FLAT || status == ST_LIMIT))
    else $error("bad status code");
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("item accepted but no work started");
endmodule

bind secant_root_finder_cubic src_checker u_src_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .status(status)
);
`default_nettype wire
